### rtl/core/hbs_pkg.sv
// Shared types and constants for the heightmap brush stamp block.
`timescale 1ns / 1ps

package hbs_pkg;

  // Offset that moves a Q5.11 world coordinate of -10.0 to zero (10.0 * 2048).
  localparam int CenterOffset = 20480;
  // Reciprocal of ten scaled by 2^19, exact for dividends below 43690.
  localparam int Recip10     = 52429;
  localparam int Recip10Sh   = 19;

  // Shared multiplier operand width (signed).
  localparam int MUL_W   = 26;
  // Divider widths: quotient bits, remainder/divisor bits.
  localparam int DIV_QW  = 17;
  localparam int DIV_RW  = 24;
  // Square root radicand width and result width.
  localparam int SQ_W    = 48;
  localparam int SQ_RW   = 24;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic div_rad;
    logic set_rad;
    logic mul_rd2;
    logic z_next;
    logic row_start;
    logic x_next;
    logic mul_dx;
    logic sqrt_go;
    logic div_f;
    logic mul_fsq;
    logic mul_del;
    logic write_cell;
    logic res_stamp;
    logic res_read;
  } hbs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic sqrt_done;
    logic r_zero;
    logic z_past;
    logic z_out;
    logic x_past;
    logic x_out;
    logic in_circle;
  } hbs_sts_t;

endpackage

### rtl/core/heightmap_circular_brush_stamp_top.sv
// Top level of the heightmap circular brush stamp block.
`timescale 1ns / 1ps

// Usage:
// A transaction is accepted at a rising edge with start high and busy low.
// in_op selects a brush stamp (0) or a single cell read (1).
// Each transaction gives exactly one result, shown for one cycle with
// out_valid high; the receiver cannot stall, so results are never held.
// A read returns its cell through the memory read and result registers.
// A stamp divides the brush radius to find the sample radius, then walks
// each row of the (2r+1) square; rows and columns outside the grid are
// stepped past, each grid cell gets a distance test, and each cell inside
// the circle takes a square root, a fraction division on the shared
// divider, two products on the single multiplier and a memory write.
// At reset the height memory is cleared by a sweep over all
// GRID_SIZE*GRID_SIZE cells (16384 at the default size); busy stays high
// during the sweep. Configuration writes go through the APB-style port:
// terrain_scale at address 0, height_limit at address 4. The user must
// write them only while the block is idle; the block does not enforce it.
module heightmap_circular_brush_stamp_top #(
  parameter int GRID_SIZE  = 128,
  parameter int MAX_RADIUS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // Command channel.
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic signed [15:0] in_center_x,
  input  logic signed [15:0] in_center_z,
  input  logic [15:0]        in_brush_radius,
  input  logic signed [15:0] in_amount,
  input  logic [6:0]         in_cell_x,
  input  logic [6:0]         in_cell_z,
  // Result channel.
  output logic               out_valid,
  output logic signed [15:0] out_cell_height,
  output logic [12:0]        out_cells_changed,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  hbs_pkg::hbs_cmd_t cmd;
  hbs_pkg::hbs_sts_t sts;

  logic [15:0]        terrain_scale_r;
  logic signed [15:0] height_limit_r;
  logic               cfg_wr;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      terrain_scale_r <= 16'd4096;
      height_limit_r  <= 16'sh7FFF;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        height_limit_r <= pwdata[15:0];
      end else begin
        terrain_scale_r <= pwdata[15:0];
      end
    end
  end

  assign prdata = paddr[2] ? {16'b0, height_limit_r} : {16'b0, terrain_scale_r};

  // Controller.
  hbs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .op_read (in_op),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Datapath.
  hbs_datapath #(
    .GRID_SIZE  (GRID_SIZE),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_center_x       (in_center_x),
    .in_center_z       (in_center_z),
    .in_brush_radius   (in_brush_radius),
    .in_amount         (in_amount),
    .in_cell_x         (in_cell_x),
    .in_cell_z         (in_cell_z),
    .terrain_scale     (terrain_scale_r),
    .height_limit      (height_limit_r),
    .out_valid         (out_valid),
    .out_cell_height   (out_cell_height),
    .out_cells_changed (out_cells_changed)
  );

  // A result only follows a cycle in which a transaction was in progress.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  // Each transaction gives a single one-cycle result.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // A read gives its cell through the memory read and result registers.
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op) |=> ##1 out_valid)
    else $error("read result missing");

  // Stamps report no height and reads report no count.
  a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cell_height == 16'sd0) || (out_cells_changed == 13'd0))
    else $error("result carries both a height and a count");

endmodule

### rtl/core/hbs_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module hbs_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              go,
  input  logic [hbs_pkg::DIV_RW-1:0]        rem_init,
  input  logic [hbs_pkg::DIV_QW-1:0]        dividend,
  input  logic [hbs_pkg::DIV_RW-1:0]        divisor,
  output logic                              done,
  output logic [hbs_pkg::DIV_QW-1:0]        quot
);

  localparam int RW = hbs_pkg::DIV_RW;
  localparam int QW = hbs_pkg::DIV_QW;
  localparam int CNTW = $clog2(QW + 1);

  logic [RW-1:0]   rem_r, rem_nxt;
  logic [QW-1:0]   dvd_r, quot_r;
  logic [RW-1:0]   div_r;
  logic [CNTW-1:0] cnt_r;
  logic [RW:0]     trial;
  logic            ge;

  // One step: bring down the next dividend bit and try to subtract.
  always_comb begin
    trial   = {rem_r, dvd_r[QW-1]};
    ge      = (trial >= {1'b0, div_r});
    rem_nxt = ge ? RW'(trial - {1'b0, div_r}) : RW'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (go) begin
      cnt_r <= CNTW'(QW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r  <= rem_init;
      dvd_r  <= dividend;
      div_r  <= divisor;
      quot_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r  <= rem_nxt;
      dvd_r  <= {dvd_r[QW-2:0], 1'b0};
      quot_r <= {quot_r[QW-2:0], ge};
    end
  end

  assign done = (cnt_r == '0);
  assign quot = quot_r;

endmodule

### rtl/core/hbs_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
`timescale 1ns / 1ps

module hbs_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [hbs_pkg::SQ_W-1:0]    radicand,
  output logic                        done,
  output logic [hbs_pkg::SQ_RW-1:0]   root
);

  localparam int W  = hbs_pkg::SQ_W;
  localparam int RW = hbs_pkg::SQ_RW;
  localparam int CNTW = $clog2(RW + 1);

  logic [W-1:0]    rad_r;
  logic [RW+1:0]   rem_r, rem_nxt;
  logic [RW-1:0]   root_r;
  logic [CNTW-1:0] cnt_r;
  logic [RW+3:0]   trial_in;
  logic [RW+3:0]   trial_sub;
  logic            ge;

  // Bring down two radicand bits and compare against 4*root + 1.
  always_comb begin
    trial_in  = {rem_r, rad_r[W-1:W-2]};
    trial_sub = {2'b00, root_r, 2'b01};
    ge        = (trial_in >= trial_sub);
    rem_nxt   = ge ? (RW+2)'(trial_in - trial_sub) : (RW+2)'(trial_in);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (go) begin
      cnt_r <= CNTW'(RW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cnt_r != '0) begin
      rad_r  <= {rad_r[W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_r[RW-2:0], ge};
    end
  end

  assign done = (cnt_r == '0);
  assign root = root_r;

endmodule

### rtl/core/hbs_datapath.sv
// Datapath: height memory, coordinate counters, shared multiplier and arithmetic units.
`timescale 1ns / 1ps

module hbs_datapath #(
  parameter int GRID_SIZE  = 128,
  parameter int MAX_RADIUS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hbs_pkg::hbs_cmd_t   cmd,
  output hbs_pkg::hbs_sts_t   sts,
  input  logic signed [15:0]  in_center_x,
  input  logic signed [15:0]  in_center_z,
  input  logic [15:0]         in_brush_radius,
  input  logic signed [15:0]  in_amount,
  input  logic [6:0]          in_cell_x,
  input  logic [6:0]          in_cell_z,
  input  logic [15:0]         terrain_scale,
  input  logic signed [15:0]  height_limit,
  output logic                out_valid,
  output logic signed [15:0]  out_cell_height,
  output logic [12:0]         out_cells_changed
);

  localparam int LG    = $clog2(GRID_SIZE);
  localparam int DEPTH = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = LG + 10;
  localparam int NW    = LG + 18;
  localparam int QW    = NW - 12;
  localparam int DW    = CW + 18;
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int MW    = hbs_pkg::MUL_W;
  localparam int PW    = 2 * MW;

  localparam logic signed [CW-1:0] GridLim = CW'(GRID_SIZE);

  // Transaction operands.
  logic signed [NW-1:0] numx_r, numz_r;
  logic signed [CW-1:0] ix_r, iz_r;
  logic signed [15:0]   amt_r;
  logic                 rd_ok_r;

  // Sample radius and derived distances.
  logic [RW-1:0]        r_r, r_cap;
  logic [23:0]          rd_r;
  logic [47:0]          rd2_r, dz2_r, dx2_r;
  logic signed [CW-1:0] z_r, x_r, r_s;

  // Falloff pipeline.
  logic [16:0]          fsq_r;
  logic signed [16:0]   delta_r;
  logic [12:0]          cnt_r;

  // Memory and clearing sweep.
  logic [15:0]          mem_r [DEPTH];
  logic [15:0]          rd_data_r;
  logic [AW-1:0]        clr_r;
  logic [AW-1:0]        rd_addr, cell_addr, port_addr;

  // Outputs.
  logic                 out_valid_r;
  logic signed [15:0]   out_cell_height_r;
  logic [12:0]          out_cells_changed_r;

  // Arithmetic units.
  logic                       div_go, sqrt_done, div_done;
  logic [hbs_pkg::DIV_RW-1:0] div_rem, div_den;
  logic [hbs_pkg::DIV_QW-1:0] div_dvd, div_q;
  logic [hbs_pkg::SQ_RW-1:0]  sq_root;
  logic [23:0]                fa;
  logic [48:0]                n2;

  // Shared multiplier.
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;

  // Coordinate helpers.
  logic signed [DW-1:0] dz_full, dx_full;
  logic signed [CW-1:0] ix_nxt;
  logic [NW-1:0]        mag;
  logic [QW+16:0]       q_prod;
  logic [QW-1:0]        q_div;
  logic signed [17:0]   h_sum, h_clamp;
  logic signed [PW-1:0] del_adj;

  // Grid centre: truncate |num| / 40960 toward zero, as /4096 then /10.
  always_comb begin
    mag    = numx_r[NW-1] ? NW'(-numx_r) : NW'(numx_r);
    q_prod = (QW+17)'(mag[NW-1:12]) * (QW+17)'(hbs_pkg::Recip10);
    q_div  = QW'(q_prod >> hbs_pkg::Recip10Sh);
    ix_nxt = numx_r[NW-1] ? -CW'($signed({1'b0, q_div})) : CW'($signed({1'b0, q_div}));
  end

  logic [NW-1:0]        magz;
  logic [QW+16:0]       qz_prod;
  logic [QW-1:0]        qz_div;
  logic signed [CW-1:0] iz_nxt;

  always_comb begin
    magz    = numz_r[NW-1] ? NW'(-numz_r) : NW'(numz_r);
    qz_prod = (QW+17)'(magz[NW-1:12]) * (QW+17)'(hbs_pkg::Recip10);
    qz_div  = QW'(qz_prod >> hbs_pkg::Recip10Sh);
    iz_nxt  = numz_r[NW-1] ? -CW'($signed({1'b0, qz_div})) : CW'($signed({1'b0, qz_div}));
  end

  // Capture the transaction and keep the grid centre up to date.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      numx_r  <= NW'((int'(in_center_x) + hbs_pkg::CenterOffset) * GRID_SIZE);
      numz_r  <= NW'((int'(in_center_z) + hbs_pkg::CenterOffset) * GRID_SIZE);
      amt_r   <= in_amount;
      rd_ok_r <= (int'(in_cell_x) < GRID_SIZE) && (int'(in_cell_z) < GRID_SIZE);
    end
    ix_r <= ix_nxt;
    iz_r <= iz_nxt;
  end

  // Shared divider: sample radius first, falloff fraction per cell.
  assign fa      = rd_r - 24'(sq_root);
  assign div_go  = cmd.div_rad | cmd.div_f;
  assign div_rem = cmd.div_rad ? '0 : {1'b0, fa[23:1]};
  assign div_dvd = cmd.div_rad ? {in_brush_radius, 1'b0} : {fa[0], 16'b0};
  assign div_den = cmd.div_rad ? 24'(terrain_scale) : rd_r;

  hbs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .rem_init (div_rem),
    .dividend (div_dvd),
    .divisor  (div_den),
    .done     (div_done),
    .quot     (div_q)
  );

  // Distance squared of the current cell.
  assign n2 = {1'b0, dx2_r} + {1'b0, dz2_r};

  hbs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.sqrt_go),
    .radicand (n2[47:0]),
    .done     (sqrt_done),
    .root     (sq_root)
  );

  // Sample radius capped at the maximum.
  assign r_cap = (div_q > hbs_pkg::DIV_QW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(div_q);
  assign r_s   = $signed({{(CW-RW){1'b0}}, r_r});

  // Offsets from the exact centre in 1/40960 of a sample.
  always_comb begin
    dz_full = (DW'(z_r) <<< 15) + (DW'(z_r) <<< 13) - DW'(numz_r);
    dx_full = (DW'(x_r) <<< 15) + (DW'(x_r) <<< 13) - DW'(numx_r);
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    priority if (cmd.mul_rd2) begin
      mul_a = MW'($signed({1'b0, rd_r}));
      mul_b = MW'($signed({1'b0, rd_r}));
    end else if (cmd.row_start) begin
      mul_a = dz_full[MW-1:0];
      mul_b = dz_full[MW-1:0];
    end else if (cmd.mul_dx) begin
      mul_a = dx_full[MW-1:0];
      mul_b = dx_full[MW-1:0];
    end else if (cmd.mul_fsq) begin
      mul_a = MW'($signed({1'b0, div_q}));
      mul_b = MW'($signed({1'b0, div_q}));
    end else if (cmd.mul_del) begin
      mul_a = MW'(amt_r);
      mul_b = MW'($signed({1'b0, fsq_r}));
    end else begin
      mul_a = '0;
      mul_b = '0;
    end
  end

  assign mul_p   = PW'(mul_a) * PW'(mul_b);
  assign del_adj = mul_p[PW-1] ? mul_p + PW'(65535) : mul_p;

  // Radius, coordinates and products.
  always_ff @(posedge clk) begin
    if (cmd.set_rad) begin
      r_r  <= r_cap;
      rd_r <= (24'(r_cap) << 15) + (24'(r_cap) << 13);
      z_r  <= iz_r - $signed({{(CW-RW){1'b0}}, r_cap});
    end else if (cmd.z_next) begin
      z_r <= z_r + 1'b1;
    end
    if (cmd.row_start) begin
      x_r <= ix_r - r_s;
    end else if (cmd.x_next) begin
      x_r <= x_r + 1'b1;
    end
    if (cmd.mul_rd2) begin
      rd2_r <= mul_p[47:0];
    end
    if (cmd.row_start) begin
      dz2_r <= mul_p[47:0];
    end
    if (cmd.mul_dx) begin
      dx2_r <= mul_p[47:0];
    end
    if (cmd.mul_fsq) begin
      fsq_r <= mul_p[32:16];
    end
    if (cmd.mul_del) begin
      delta_r <= del_adj[32:16];
    end
  end

  // Cell counter, wrapping at 13 bits.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cnt_r <= '0;
    end else if (cmd.write_cell) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Clamp the updated height.
  always_comb begin
    h_sum   = 18'($signed(rd_data_r)) + 18'(delta_r);
    h_clamp = h_sum;
    if (h_sum > 18'(height_limit)) begin
      h_clamp = 18'(height_limit);
    end
    if (h_clamp < -18'sd32768) begin
      h_clamp = -18'sd32768;
    end
  end

  // Memory addressing.
  assign cell_addr = AW'(int'(z_r[LG-1:0]) * GRID_SIZE + int'(x_r[LG-1:0]));
  assign port_addr = AW'(int'(in_cell_z) * GRID_SIZE + int'(in_cell_x));
  assign rd_addr   = cmd.capture ? port_addr : cell_addr;

  // Clearing sweep address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // Height memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem_r[clr_r] <= '0;
    end else if (cmd.write_cell) begin
      mem_r[cell_addr] <= h_clamp[15:0];
    end
    rd_data_r <= mem_r[rd_addr];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.res_stamp | cmd.res_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_read) begin
      out_cell_height_r   <= rd_ok_r ? $signed(rd_data_r) : 16'sd0;
      out_cells_changed_r <= '0;
    end else if (cmd.res_stamp) begin
      out_cell_height_r   <= 16'sd0;
      out_cells_changed_r <= cnt_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cell_height   = out_cell_height_r;
  assign out_cells_changed = out_cells_changed_r;

  // Status to the controller.
  always_comb begin
    sts.clr_last  = (clr_r == AW'(DEPTH - 1));
    sts.div_done  = div_done;
    sts.sqrt_done = sqrt_done;
    sts.r_zero    = (r_cap == '0);
    sts.z_past    = (z_r > iz_r + r_s);
    sts.z_out     = (z_r < 0) || (z_r >= GridLim);
    sts.x_past    = (x_r > ix_r + r_s);
    sts.x_out     = (x_r < 0) || (x_r >= GridLim);
    sts.in_circle = (n2 <= {1'b0, rd2_r});
  end

endmodule

### rtl/core/hbs_ctrl.sv
// Controller state machine that sequences clearing, reads and brush stamps.
`timescale 1ns / 1ps

module hbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              op_read,
  input  hbs_pkg::hbs_sts_t sts,
  output hbs_pkg::hbs_cmd_t cmd,
  output logic              busy
);

  typedef enum logic [15:0] {
    ST_CLEAR = 16'h0001,
    ST_IDLE  = 16'h0002,
    ST_RDOUT = 16'h0004,
    ST_DIVR  = 16'h0008,
    ST_RSET  = 16'h0010,
    ST_RD2   = 16'h0020,
    ST_ROW   = 16'h0040,
    ST_COL   = 16'h0080,
    ST_TEST  = 16'h0100,
    ST_SQRT  = 16'h0200,
    ST_DIVF  = 16'h0400,
    ST_FSQ   = 16'h0800,
    ST_DEL   = 16'h1000,
    ST_UPD   = 16'h2000,
    ST_DONE  = 16'h4000,
    ST_SPARE = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          if (op_read) begin
            state_nxt = ST_RDOUT;
          end else begin
            cmd.div_rad = 1'b1;
            state_nxt   = ST_DIVR;
          end
        end
      end
      ST_RDOUT: begin
        cmd.res_read = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_DIVR: begin
        if (sts.div_done) begin
          state_nxt = ST_RSET;
        end
      end
      ST_RSET: begin
        cmd.set_rad = 1'b1;
        state_nxt   = sts.r_zero ? ST_DONE : ST_RD2;
      end
      ST_RD2: begin
        cmd.mul_rd2 = 1'b1;
        state_nxt   = ST_ROW;
      end
      ST_ROW: begin
        priority if (sts.z_past) begin
          state_nxt = ST_DONE;
        end else if (sts.z_out) begin
          cmd.z_next = 1'b1;
        end else begin
          cmd.row_start = 1'b1;
          state_nxt     = ST_COL;
        end
      end
      ST_COL: begin
        priority if (sts.x_past) begin
          cmd.z_next = 1'b1;
          state_nxt  = ST_ROW;
        end else if (sts.x_out) begin
          cmd.x_next = 1'b1;
        end else begin
          cmd.mul_dx = 1'b1;
          state_nxt  = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sts.in_circle) begin
          cmd.sqrt_go = 1'b1;
          state_nxt   = ST_SQRT;
        end else begin
          cmd.x_next = 1'b1;
          state_nxt  = ST_COL;
        end
      end
      ST_SQRT: begin
        if (sts.sqrt_done) begin
          cmd.div_f = 1'b1;
          state_nxt = ST_DIVF;
        end
      end
      ST_DIVF: begin
        if (sts.div_done) begin
          state_nxt = ST_FSQ;
        end
      end
      ST_FSQ: begin
        cmd.mul_fsq = 1'b1;
        state_nxt   = ST_DEL;
      end
      ST_DEL: begin
        cmd.mul_del = 1'b1;
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        cmd.write_cell = 1'b1;
        cmd.x_next     = 1'b1;
        state_nxt      = ST_COL;
      end
      ST_DONE: begin
        cmd.res_stamp = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

### sim/tb_top.sv
// Self-checking testbench for the heightmap circular brush stamp block.
`timescale 1ns / 1ps

module tb_top;

  localparam int GRID         = 128;
  localparam int RAD_CAP      = 32;
  localparam int WORLD_SPAN   = 40960;
  localparam int WATCHDOG_MAX = 1000000;

  localparam logic OP_STAMP = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [2:0] ADDR_TERRAIN_SCALE = 3'd0;
  localparam logic [2:0] ADDR_HEIGHT_LIMIT  = 3'd4;

  typedef struct {
    logic              op;
    logic signed [15:0] cx;
    logic signed [15:0] cz;
    logic [15:0]        rad;
    logic signed [15:0] amt;
    logic [6:0]         clx;
    logic [6:0]         clz;
  } brush_cmd_t;

  typedef struct {
    logic signed [15:0] height;
    logic [12:0]        changed;
  } readout_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               start = 1'b0;
  logic               busy;
  logic               in_op = 1'b0;
  logic signed [15:0] in_center_x = '0;
  logic signed [15:0] in_center_z = '0;
  logic [15:0]        in_brush_radius = '0;
  logic signed [15:0] in_amount = '0;
  logic [6:0]         in_cell_x = '0;
  logic [6:0]         in_cell_z = '0;
  logic               out_valid;
  logic signed [15:0] out_cell_height;
  logic [12:0]        out_cells_changed;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  heightmap_circular_brush_stamp_top #(
    .GRID_SIZE (GRID),
    .MAX_RADIUS(RAD_CAP)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_op(in_op), .in_center_x(in_center_x), .in_center_z(in_center_z),
    .in_brush_radius(in_brush_radius), .in_amount(in_amount),
    .in_cell_x(in_cell_x), .in_cell_z(in_cell_z),
    .out_valid(out_valid), .out_cell_height(out_cell_height),
    .out_cells_changed(out_cells_changed),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirror of the block state used for prediction.
  logic signed [15:0] height_mirror [0:GRID*GRID-1];
  logic [15:0]        scale_reg;
  logic signed [15:0] limit_reg;

  brush_cmd_t pending_cmds[$];
  readout_t   expected_readouts[$];

  bit     idle_enable = 1'b1;
  int     gap_left = 0;
  int     error_count = 0;
  int     stamp_count = 0;
  int     read_count = 0;
  longint cells_total = 0;
  int     quiet_cycles = 0;

  // Floor of the square root, one result bit at a time.
  function automatic longint root_floor(longint n);
    longint res;
    longint trial;
    res = 0;
    for (int b = 23; b >= 0; b--) begin
      trial = res | (longint'(1) << b);
      if (trial * trial <= n) res = trial;
    end
    return res;
  endfunction

  // Apply one stamp to the mirror and return the number of cells touched.
  function automatic logic [12:0] stamp_grid(logic signed [15:0] cx,
                                             logic signed [15:0] cz,
                                             logic [15:0] rad,
                                             logic signed [15:0] amt);
    longint numx, numz, ix, iz, r, rd, dx, dz, n2, s, f, fsq, delta, h;
    int     idx;
    longint count;
    numx = (longint'(cx) + hbs_pkg::CenterOffset) * GRID;
    numz = (longint'(cz) + hbs_pkg::CenterOffset) * GRID;
    ix = numx / WORLD_SPAN;
    iz = numz / WORLD_SPAN;
    count = 0;
    if (scale_reg == 0) r = RAD_CAP;
    else r = (longint'(rad) * 2) / longint'(scale_reg);
    if (r > RAD_CAP) r = RAD_CAP;
    if (r == 0) return '0;
    rd = r * WORLD_SPAN;
    for (longint z = iz - r; z <= iz + r; z++) begin
      if (z < 0 || z >= GRID) continue;
      for (longint x = ix - r; x <= ix + r; x++) begin
        if (x < 0 || x >= GRID) continue;
        dx = x * WORLD_SPAN - numx;
        dz = z * WORLD_SPAN - numz;
        n2 = dx * dx + dz * dz;
        if (n2 > rd * rd) continue;
        s = root_floor(n2);
        if (s > rd) s = rd;
        f = ((rd - s) << 16) / rd;
        fsq = (f * f) >>> 16;
        delta = (longint'(amt) * fsq) / 65536;
        idx = int'(z) * GRID + int'(x);
        h = longint'(height_mirror[idx]) + delta;
        if (h > longint'(limit_reg)) h = longint'(limit_reg);
        if (h < -32768) h = -32768;
        height_mirror[idx] = h[15:0];
        count++;
      end
    end
    return count[12:0];
  endfunction

  // Work out the result of one accepted transaction.
  function automatic readout_t predict_readout(brush_cmd_t c);
    readout_t o;
    o.height = '0;
    o.changed = '0;
    if (c.op == OP_STAMP) o.changed = stamp_grid(c.cx, c.cz, c.rad, c.amt);
    else o.height = height_mirror[int'(c.clz) * GRID + int'(c.clx)];
    return o;
  endfunction

  // Driver: present queued transactions and predict each one as it is taken.
  always @(posedge clk) begin
    brush_cmd_t c;
    if (rst_n) begin
      if (start && !busy) begin
        c.op = in_op; c.cx = in_center_x; c.cz = in_center_z;
        c.rad = in_brush_radius; c.amt = in_amount;
        c.clx = in_cell_x; c.clz = in_cell_z;
        expected_readouts.push_back(predict_readout(c));
        if (idle_enable && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 8);
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds.pop_front();
          in_op <= c.op; in_center_x <= c.cx; in_center_z <= c.cz;
          in_brush_radius <= c.rad; in_amount <= c.amt;
          in_cell_x <= c.clx; in_cell_z <= c.clz;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every result with the oldest expectation.
  always @(posedge clk) begin
    readout_t e;
    if (rst_n && out_valid) begin
      if (expected_readouts.size() == 0) begin
        $display("%0t: unexpected result height=%0d changed=%0d",
                 $time, out_cell_height, out_cells_changed);
        error_count++;
      end else begin
        e = expected_readouts.pop_front();
        if (out_cell_height !== e.height) begin
          $display("%0t: cell_height expected %0d actual %0d",
                   $time, e.height, out_cell_height);
          error_count++;
        end
        if (out_cells_changed !== e.changed) begin
          $display("%0t: cells_changed expected %0d actual %0d",
                   $time, e.changed, out_cells_changed);
          error_count++;
        end
        cells_total += e.changed;
      end
    end
  end

  // Watchdog on cycles without any accepted transaction or result.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("%0t: watchdog expired", $time);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic push_stamp(int cx, int cz, int rad, int amt);
    brush_cmd_t c;
    c.op = OP_STAMP; c.cx = cx[15:0]; c.cz = cz[15:0]; c.rad = rad[15:0];
    c.amt = amt[15:0]; c.clx = 7'($urandom); c.clz = 7'($urandom);
    pending_cmds.push_back(c);
    stamp_count++;
  endtask

  task automatic push_read(int x, int z);
    brush_cmd_t c;
    c.op = OP_READ; c.cx = 16'($urandom); c.cz = 16'($urandom);
    c.rad = 16'($urandom); c.amt = 16'($urandom);
    c.clx = x[6:0]; c.clz = z[6:0];
    pending_cmds.push_back(c);
    read_count++;
  endtask

  // Wait until every queued transaction has produced its result.
  task automatic drain();
    do @(negedge clk);
    while (pending_cmds.size() > 0 || start || busy || expected_readouts.size() > 0);
    repeat (8) @(negedge clk);
  endtask

  // Setup then access phase; the register takes the write on the access edge.
  task automatic write_reg(logic [2:0] addr, logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= addr; pwdata <= {{16{value[15] & (addr == ADDR_HEIGHT_LIMIT)}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_TERRAIN_SCALE) scale_reg = value;
    else limit_reg = value;
  endtask

  // Random mix of stamps and reads; radii mostly kept to a few samples.
  task automatic random_phase(int n);
    int cx, cz, cap, lx, lz;
    lx = 64; lz = 64;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 6) begin
        if ($urandom_range(0, 9) < 3) begin
          cx = $signed(16'($urandom)); cz = $signed(16'($urandom));
        end else begin
          cx = $urandom_range(0, 40959) - 20480;
          cz = $urandom_range(0, 40959) - 20480;
        end
        cap = (scale_reg == 0) ? 0 : int'(scale_reg) * 2;
        if (cap > 65535) cap = 65535;
        push_stamp(cx, cz, $urandom_range(0, cap), $signed(16'($urandom)));
        lx = ((cx + hbs_pkg::CenterOffset) * GRID) / WORLD_SPAN;
        lz = ((cz + hbs_pkg::CenterOffset) * GRID) / WORLD_SPAN;
      end else if ($urandom_range(0, 1) == 0 && lx >= 0 && lx < GRID
                   && lz >= 0 && lz < GRID) begin
        push_read(lx, lz);
      end else begin
        push_read($urandom_range(0, 127), $urandom_range(0, 127));
      end
    end
  endtask

  // Stimulus and end of run.
  initial begin
    for (int i = 0; i < GRID * GRID; i++) height_mirror[i] = '0;
    scale_reg = 16'd4096;
    limit_reg = 16'sd32767;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings.
    push_read(0, 0);
    push_read(127, 127);
    push_stamp(0, 0, 16384, 32767);
    push_read(64, 64);
    push_stamp(0, 0, 16384, 32767);
    push_read(64, 64);
    push_stamp(0, 0, 0, 500);
    push_stamp(0, 0, 2047, 500);
    push_stamp(-32768, -32768, 8192, -32768);
    push_stamp(32767, 32767, 65535, 100);
    push_stamp(-20480, -20480, 65535, -32768);
    push_stamp(-20480, -20480, 65535, -32768);
    push_read(0, 0);
    push_read(3, 1);
    push_stamp(0, 0, 65535, -32768);
    push_read(64, 64);
    push_read(40, 70);
    drain();

    // Smallest scale caps the radius; lowest height limit.
    write_reg(ADDR_TERRAIN_SCALE, 16'd1);
    write_reg(ADDR_HEIGHT_LIMIT, 16'h8000);
    push_stamp(-20480, -20480, 65535, 32767);
    push_read(5, 5);
    push_read(127, 0);
    drain();

    // Zero scale gives the largest radius, capped at the maximum.
    write_reg(ADDR_TERRAIN_SCALE, 16'd0);
    write_reg(ADDR_HEIGHT_LIMIT, 16'd1000);
    push_stamp(20479, -20480, 0, 5000);
    push_read(127, 0);
    push_read(120, 3);
    drain();

    // Largest scale leaves only tiny radii.
    write_reg(ADDR_TERRAIN_SCALE, 16'hFFFF);
    write_reg(ADDR_HEIGHT_LIMIT, 16'h7FFF);
    push_stamp(0, 0, 65535, 1);
    push_stamp(0, 0, 32767, 1);
    push_read(64, 64);
    drain();

    // Random phases at assorted settings.
    write_reg(ADDR_TERRAIN_SCALE, 16'($urandom_range(32768, 65535)));
    write_reg(ADDR_HEIGHT_LIMIT, 16'($urandom_range(0, 32767)));
    random_phase(35);
    drain();
    write_reg(ADDR_TERRAIN_SCALE, 16'($urandom_range(4096, 32767)));
    write_reg(ADDR_HEIGHT_LIMIT, 16'($urandom));
    random_phase(35);
    drain();

    // Last stretch runs back to back at reset settings.
    write_reg(ADDR_TERRAIN_SCALE, 16'd4096);
    write_reg(ADDR_HEIGHT_LIMIT, 16'h7FFF);
    idle_enable = 1'b0;
    random_phase(35);
    drain();
    repeat (20) @(negedge clk);

    $display("Covered %0d stamps and %0d reads, %0d cell updates checked,",
             stamp_count, read_count, cells_total);
    $display("over scale and limit extremes including zero scale.");
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/hbs_pkg.sv
rtl/core/hbs_div.sv
rtl/core/hbs_sqrt.sv
rtl/core/hbs_datapath.sv
rtl/core/hbs_ctrl.sv
rtl/core/heightmap_circular_brush_stamp_top.sv
sim/tb_top.sv
